@@ rtl/cia_pkg.sv @@
`timescale 1ns / 1ps
package cia_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW = 6;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages = DataW / DivStepsPerStage;

  typedef enum logic [2:0] {
    FuncAdd  = 3'd0,
    FuncSub  = 3'd1,
    FuncMul  = 3'd2,
    FuncDiv  = 3'd3,
    FuncRem  = 3'd4,
    FuncShl  = 3'd5,
    FuncRotl = 3'd6,
    FuncRotr = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StOvf   = 2'd1,
    StDiv0  = 2'd2,
    StShift = 2'd3
  } status_e;

  typedef struct packed {
    logic [DataW-1:0] value;
    status_e          status;
  } res_t;

  typedef struct packed {
    logic             is_div;
    logic             is_rem;
    logic             neg_q;
    logic             neg_r;
    logic             early;
    res_t             early_res;
  } div_ctl_t;
endpackage

@@ rtl/cia_div_stage.sv @@
`timescale 1ns / 1ps
module cia_div_stage (
  input  logic [cia_pkg::DataW-1:0] rem_i,
  input  logic [cia_pkg::DataW-1:0] quo_i,
  input  logic [cia_pkg::DataW-1:0] den_i,
  output logic [cia_pkg::DataW-1:0] rem_o,
  output logic [cia_pkg::DataW-1:0] quo_o
);
  import cia_pkg::*;

  logic [DataW:0]   trial;
  logic [DataW-1:0] r;
  logic [DataW-1:0] q;

  always_comb begin
    r = rem_i;
    q = quo_i;
    trial = '0;
    for (int i = 0; i < DivStepsPerStage; i++) begin
      trial = {r, q[DataW-1]} - {1'b0, den_i};
      q = {q[DataW-2:0], ~trial[DataW]};
      if (!trial[DataW]) begin
        r = trial[DataW-1:0];
      end else begin
        r = {r[DataW-2:0], quo_i[DataW-1-i]};
      end
    end
    rem_o = r;
    quo_o = q;
  end
endmodule

@@ rtl/cia_front.sv @@
`timescale 1ns / 1ps
module cia_front (
  input  logic [2:0]                func_i,
  input  logic [cia_pkg::DataW-1:0] operand_a_i,
  input  logic [cia_pkg::DataW-1:0] operand_b_i,
  input  logic [cia_pkg::AmtW-1:0]  shift_amount_i,
  output cia_pkg::div_ctl_t         ctl_o,
  output logic [cia_pkg::DataW-1:0] dvd_o,
  output logic [cia_pkg::DataW-1:0] den_o,
  output logic                      is_mul_o
);
  import cia_pkg::*;

  logic [DataW:0]   sum;
  logic [DataW:0]   dif;
  logic [4:0]       amt;
  logic [4:0]       ramt;
  logic [2*DataW-1:0] rot2;
  logic [2*DataW-1:0] shl_w;
  logic             a_min;
  logic             b_m1;
  logic             b_zero;
  res_t             r;
  func_e            f;

  assign f      = func_e'(func_i);
  assign sum    = {operand_a_i[DataW-1], operand_a_i} + {operand_b_i[DataW-1], operand_b_i};
  assign dif    = {operand_a_i[DataW-1], operand_a_i} - {operand_b_i[DataW-1], operand_b_i};
  assign amt    = shift_amount_i[4:0];
  assign ramt   = (f == FuncRotr) ? 5'(6'd32 - {1'b0, amt}) : amt;
  assign rot2   = {operand_a_i, operand_a_i} << ramt;
  assign shl_w  = {{DataW{1'b0}}, operand_a_i} << amt;
  assign a_min  = operand_a_i == {1'b1, {(DataW-1){1'b0}}};
  assign b_m1   = &operand_b_i;
  assign b_zero = operand_b_i == '0;
  assign dvd_o  = operand_a_i[DataW-1] ? (~operand_a_i + 1'b1) : operand_a_i;
  assign den_o  = operand_b_i[DataW-1] ? (~operand_b_i + 1'b1) : operand_b_i;
  assign is_mul_o = f == FuncMul;

  always_comb begin
    r = '{value: '0, status: StOk};
    unique case (f)
      FuncAdd: begin
        if (sum[DataW] != sum[DataW-1]) r.status = StOvf;
        else r.value = sum[DataW-1:0];
      end
      FuncSub: begin
        if (dif[DataW] != dif[DataW-1]) r.status = StOvf;
        else r.value = dif[DataW-1:0];
      end
      FuncMul: r = '{value: '0, status: StOk};
      FuncDiv: begin
        if (b_zero) r = '{value: '1, status: StDiv0};
        else if (a_min && b_m1) r.status = StOvf;
      end
      FuncRem: begin
        if (b_zero || (a_min && b_m1)) r.status = StOvf;
      end
      FuncShl: begin
        if (shift_amount_i[5] || shl_w[2*DataW-1:DataW] != '0) r.status = StShift;
        else r.value = shl_w[DataW-1:0];
      end
      FuncRotl, FuncRotr: r.value = rot2[2*DataW-1:DataW];
      default: r = '{value: '0, status: StOk};
    endcase
    ctl_o.is_div    = f == FuncDiv;
    ctl_o.is_rem    = f == FuncRem;
    ctl_o.neg_q     = operand_a_i[DataW-1] ^ operand_b_i[DataW-1];
    ctl_o.neg_r     = operand_a_i[DataW-1];
    ctl_o.early     = !(f == FuncDiv || f == FuncRem || f == FuncMul) || r.status != StOk;
    ctl_o.early_res = r;
  end
endmodule

@@ rtl/checked_integer_alu_core.sv @@
`timescale 1ns / 1ps
// Checked 32-bit integer ALU. One beat in per cycle, one result beat out per
// beat in, in order. Each beat passes through the input register, the restoring
// divider stages that retire four quotient bits per pipeline stage, and then
// the output register; every operation travels the same pipeline. The
// multiplier is split into four 16x16 partial products across the first stages.
// Stalls on the output freeze the whole pipeline; with ready high a new beat
// enters every cycle.
module checked_integer_alu_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                func_i,
  input  logic signed [cia_pkg::DataW-1:0] operand_a_i,
  input  logic signed [cia_pkg::DataW-1:0] operand_b_i,
  input  logic [cia_pkg::AmtW-1:0]  shift_amount_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [cia_pkg::DataW-1:0] result_value_o,
  output logic [1:0]                status_o
);
  import cia_pkg::*;

  localparam int unsigned NStg = DivStages + 1;
  localparam int unsigned HW = DataW / 2;

  div_ctl_t         ctl_d;
  logic [DataW-1:0] dvd_d;
  logic [DataW-1:0] den_d;
  logic             mul_d;
  logic             adv;

  logic             v_q   [NStg];
  div_ctl_t         ctl_q [NStg];
  logic             mul_q [NStg];
  logic [DataW-1:0] rem_q [NStg];
  logic [DataW-1:0] quo_q [NStg];
  logic [DataW-1:0] den_q [NStg];
  logic [DataW-1:0] rem_n [DivStages];
  logic [DataW-1:0] quo_n [DivStages];

  logic [DataW-1:0]   pp_q [4];
  logic [2*DataW-1:0] prod_q [NStg-1];
  logic               sa_q, sb_q;
  logic [2*DataW-1:0] sprod;
  logic [2*DataW-1:0] prod_w;

  res_t             fin_d;
  res_t             out_q;
  logic             ov_q;
  logic [DataW-1:0] qs;
  logic [DataW-1:0] rs;

  cia_front u_front (
    .func_i         (func_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .shift_amount_i (shift_amount_i),
    .ctl_o          (ctl_d),
    .dvd_o          (dvd_d),
    .den_o          (den_d),
    .is_mul_o       (mul_d)
  );

  assign adv        = !ov_q || out_ready_i;
  assign in_ready_o = adv;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    cia_div_stage u_stage (
      .rem_i (rem_q[s]),
      .quo_i (quo_q[s]),
      .den_i (den_q[s]),
      .rem_o (rem_n[s]),
      .quo_o (quo_n[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NStg; s++) v_q[s] <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int s = 1; s < NStg; s++) v_q[s] <= v_q[s-1];
      ov_q <= v_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_d;
      mul_q[0] <= mul_d;
      rem_q[0] <= '0;
      quo_q[0] <= dvd_d;
      den_q[0] <= den_d;
      for (int s = 1; s < NStg; s++) begin
        ctl_q[s] <= ctl_q[s-1];
        mul_q[s] <= mul_q[s-1];
        rem_q[s] <= rem_n[s-1];
        quo_q[s] <= quo_n[s-1];
        den_q[s] <= den_q[s-1];
      end
      pp_q[0] <= DataW'(dvd_d[HW-1:0]) * DataW'(den_d[HW-1:0]);
      pp_q[1] <= DataW'(dvd_d[DataW-1:HW]) * DataW'(den_d[HW-1:0]);
      pp_q[2] <= DataW'(dvd_d[HW-1:0]) * DataW'(den_d[DataW-1:HW]);
      pp_q[3] <= DataW'(dvd_d[DataW-1:HW]) * DataW'(den_d[DataW-1:HW]);
      sa_q    <= operand_a_i[DataW-1];
      sb_q    <= operand_b_i[DataW-1];
      prod_q[0] <= sprod;
      for (int s = 1; s < NStg-1; s++) prod_q[s] <= prod_q[s-1];
      out_q   <= fin_d;
    end
  end

  // Magnitude product; sign applied in the same stage, checked at the end.
  assign prod_w = {pp_q[3], pp_q[0]}
                + ({{HW{1'b0}}, pp_q[1], {HW{1'b0}}})
                + ({{HW{1'b0}}, pp_q[2], {HW{1'b0}}});
  assign sprod  = (sa_q ^ sb_q) ? (~prod_w + 1'b1) : prod_w;

  always_comb begin
    qs    = ctl_q[NStg-1].neg_q ? (~quo_q[NStg-1] + 1'b1) : quo_q[NStg-1];
    rs    = ctl_q[NStg-1].neg_r ? (~rem_q[NStg-1] + 1'b1) : rem_q[NStg-1];
    fin_d = ctl_q[NStg-1].early_res;
    if (!ctl_q[NStg-1].early) begin
      if (mul_q[NStg-1]) begin
        if (prod_q[NStg-2][2*DataW-1:DataW-1] != '0 &&
            prod_q[NStg-2][2*DataW-1:DataW-1] != '1) begin
          fin_d = '{value: '0, status: StOvf};
        end else begin
          fin_d = '{value: prod_q[NStg-2][DataW-1:0], status: StOk};
        end
      end else if (ctl_q[NStg-1].is_div) begin
        fin_d = '{value: qs, status: StOk};
      end else begin
        fin_d = '{value: rs, status: StOk};
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = out_q.value;
  assign status_o       = out_q.status;
endmodule

@@ tb/checked_integer_alu_checker.sv @@
`timescale 1ns / 1ps
module checked_integer_alu_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [2:0]                        func_i,
  input  logic signed [cia_pkg::DataW-1:0]  operand_a_i,
  input  logic signed [cia_pkg::DataW-1:0]  operand_b_i,
  input  logic [cia_pkg::AmtW-1:0]          shift_amount_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [cia_pkg::DataW-1:0]  result_value_i,
  input  logic [1:0]                        status_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       result_count_o
);
  import cia_pkg::*;

  res_t alu_results_q[$];

  function automatic res_t alu_result(func_e op, logic signed [31:0] a,
                                      logic signed [31:0] b, logic [5:0] amt);
    res_t r;
    logic signed [63:0] wide;
    logic [31:0] bits;
    logic [4:0] rot;
    logic check_fit;
    r.value = '0;
    r.status = StOk;
    wide = '0;
    check_fit = 1'b1;
    case (op)
      FuncAdd: wide = 64'(a) + 64'(b);
      FuncSub: wide = 64'(a) - 64'(b);
      FuncMul: wide = 64'(a) * 64'(b);
      FuncDiv: begin
        if (b == 0) begin
          r.status = StDiv0;
          r.value = '1;
          check_fit = 1'b0;
        end else begin
          wide = 64'(a) / 64'(b);
        end
      end
      FuncRem: begin
        if (b == 0 || (a == 32'sh8000_0000 && b == -1)) begin
          r.status = StOvf;
          check_fit = 1'b0;
        end else begin
          wide = 64'(a) % 64'(b);
        end
      end
      FuncShl: begin
        check_fit = 1'b0;
        bits = a;
        if (amt >= 6'd32) begin
          r.status = StShift;
        end else if (amt != 0 && (bits >> (32 - amt)) != 0) begin
          r.status = StShift;
        end else begin
          r.value = bits << amt;
        end
      end
      default: begin
        check_fit = 1'b0;
        bits = a;
        rot = (op == FuncRotl) ? amt[4:0] : 5'(32 - amt[4:0]);
        r.value = (rot == 0) ? bits : ((bits << rot) | (bits >> (32 - rot)));
      end
    endcase
    if (check_fit) begin
      if (wide > 64'sd2147483647 || wide < -64'sd2147483648) begin
        r.status = StOvf;
        r.value = '0;
      end else begin
        r.value = wide[31:0];
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
      result_count_o <= 0;
      alu_results_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        alu_results_q.push_back(alu_result(func_e'(func_i), operand_a_i, operand_b_i,
                                           shift_amount_i));
      end
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (alu_results_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %h/%0d",
                                          result_value_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = alu_results_q.pop_front();
          if (exp_r.value !== result_value_i || exp_r.status !== status_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %h/%0d, got %h/%0d", exp_r.value,
                       exp_r.status, result_value_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = alu_results_q.size();
endmodule

@@ tb/checked_integer_alu_core_test.sv @@
`timescale 1ns / 1ps
module checked_integer_alu_core_test;
  import cia_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] func_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic [5:0] shift_amount_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [1:0] status_o;
  int unsigned fail_count, pending, result_count;
  int unsigned cycle_count = 0;
  logic hold_off = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  checked_integer_alu_core DUT (.*);

  checked_integer_alu_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .operand_a_i,
    .operand_b_i, .shift_amount_i, .out_valid_i(out_valid_o), .out_ready_i,
    .result_value_i(result_value_o), .status_i(status_o), .fail_count_o(fail_count),
    .pending_o(pending), .result_count_o(result_count)
  );

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(int'($urandom_range(0, 20)) - 10);
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(func_e op, logic [31:0] a, logic [31:0] b, logic [5:0] amt,
                           int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    shift_amount_i <= amt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned wait_cycles;
    @(posedge clk_i);
    while (rst_ni) @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      wait_cycles = hold_off ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
      if (wait_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready_i <= !hold_off;
      @(posedge clk_i);
      while (hold_off) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] a, b;
    func_e op;
    int unsigned i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_beat(FuncAdd, 32'h7fff_ffff, 32'd1, 6'd0, 0);
    send_beat(FuncAdd, 32'h8000_0000, 32'hffff_ffff, 6'd63, 0);
    send_beat(FuncSub, 32'h8000_0000, 32'd1, 6'd0, 0);
    send_beat(FuncSub, 32'd5, 32'd9, 6'd0, 0);
    send_beat(FuncMul, 32'h0001_0000, 32'h0001_0000, 6'd0, 0);
    send_beat(FuncMul, 32'h8000_0000, 32'hffff_ffff, 6'd0, 0);
    send_beat(FuncMul, 32'hffff_fff9, 32'd3, 6'd0, 0);
    send_beat(FuncDiv, 32'd7, 32'd0, 6'd0, 0);
    send_beat(FuncDiv, 32'h8000_0000, 32'hffff_ffff, 6'd0, 0);
    send_beat(FuncDiv, 32'hffff_fff9, 32'd2, 6'd0, 0);
    send_beat(FuncRem, 32'd7, 32'd0, 6'd0, 0);
    send_beat(FuncRem, 32'h8000_0000, 32'hffff_ffff, 6'd0, 0);
    send_beat(FuncRem, 32'hffff_fff9, 32'd2, 6'd0, 0);
    send_beat(FuncShl, 32'd1, 32'd0, 6'd31, 0);
    send_beat(FuncShl, 32'd1, 32'd0, 6'd32, 0);
    send_beat(FuncShl, 32'd3, 32'd0, 6'd31, 0);
    send_beat(FuncShl, 32'hffff_ffff, 32'd0, 6'd0, 0);
    send_beat(FuncRotl, 32'h8000_0001, 32'd0, 6'd33, 0);
    send_beat(FuncRotl, 32'h1234_5678, 32'd0, 6'd32, 0);
    send_beat(FuncRotr, 32'h8000_0001, 32'd0, 6'd1, 0);
    send_beat(FuncRotr, 32'h1234_5678, 32'd0, 6'd0, 0);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (i = 0; i < 600; i++) begin
      if (i == 200) begin
        hold_off <= 1'b1;
        fork
          begin
            repeat (60) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      if (i == 400) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      op = func_e'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      if (op == FuncShl && $urandom_range(0, 1)) a = $urandom >> $urandom_range(0, 31);
      send_beat(op, a, b, 6'($urandom_range(0, 63)),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Ran all eight operations with edge operands, zero divisors and shift limits;");
    $display("%0d result beats checked under random stalls and a long output hold-off.",
             result_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/cia_pkg.sv
rtl/cia_div_stage.sv
rtl/cia_front.sv
rtl/checked_integer_alu_core.sv
tb/checked_integer_alu_checker.sv
tb/checked_integer_alu_core_test.sv
